/* rtl/pn2_pkg.sv */
// Shared constants, command codes and inter-module bundles for the 2D gradient noise core.
// No dependencies; imported by every module of the core except the generic RAM.
`default_nettype none

package pn2_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int TABLE_SIZE = 256;
	localparam int IDX_W      = $clog2(TABLE_SIZE);

	// Beat field widths
	localparam int TIDX_W  = 8;
	localparam int ENTRY_W = 8;
	localparam int COORD_W = 24;
	localparam int OUT_W   = 19;

	// Datapath widths
	localparam int HASH_W = 3;
	localparam int U_W    = FRAC_BITS + 1;   // fade weight, 0..one
	localparam int P_W    = FRAC_BITS + 4;   // 6t^2 - 15t + 10, unsigned
	localparam int G_W    = FRAC_BITS + 3;   // gradient dot, signed
	localparam int D_W    = G_W + 1;         // gradient difference
	localparam int L_W    = G_W + 1;         // lerp result
	localparam int DL_W   = L_W + 1;         // lerp difference
	localparam int R_W    = L_W + 1;         // final lerp sum

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_EVAL = 1'b1
	} cmd_t;

	typedef struct packed {
		logic                 ld;
		logic [IDX_W-1:0]     idx;
		logic [ENTRY_W-1:0]   value;
		logic [IDX_W-1:0]     cx;
		logic [IDX_W-1:0]     cy;
	} tbl_req_t;

	typedef struct packed {
		logic [HASH_W-1:0] h00;
		logic [HASH_W-1:0] h10;
		logic [HASH_W-1:0] h01;
		logic [HASH_W-1:0] h11;
	} hash_t;

endpackage

`default_nettype wire

/* rtl/pn2_ram.sv */
// Generic RAM, one write port and two registered read ports sharing a read enable.
// No dependencies.
`default_nettype none

module pn2_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata0_q,
	output logic [WIDTH-1:0]         rdata1_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata0_q <= mem_q[raddr0];
			rdata1_q <= mem_q[raddr1];
		end
	end

endmodule

`default_nettype wire

/* rtl/pn2_hash.sv */
// Corner hashing: three levels of permutation lookups over five table copies.
// Depends on pn2_pkg and pn2_ram.
`default_nettype none

module pn2_hash (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  pn2_pkg::tbl_req_t req_s1,
	output pn2_pkg::hash_t   hash_s4
);
	import pn2_pkg::*;

	// Each copy is written when a load beat passes the stage that reads it,
	// so every lookup sees exactly the loads that came before its beat.
	logic               ld_s2, ld_s3;
	logic [IDX_W-1:0]   idx_s2, idx_s3, cy_s2;
	logic [ENTRY_W-1:0] val_s2, val_s3;
	logic [ENTRY_W-1:0] pa_s2, pb_s2;
	logic [ENTRY_W-1:0] aa_s3, ab_s3, ba_s3, bb_s3;
	logic [ENTRY_W-1:0] haa_s4, hab_s4, hba_s4, hbb_s4;
	logic [IDX_W-1:0]   cx1, a_addr, a1_addr, b_addr, b1_addr;

	assign cx1     = req_s1.cx + IDX_W'(1);
	assign a_addr  = IDX_W'(pa_s2) + cy_s2;
	assign a1_addr = a_addr + IDX_W'(1);
	assign b_addr  = IDX_W'(pb_s2) + cy_s2;
	assign b1_addr = b_addr + IDX_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_s2 <= 1'b0;
			ld_s3 <= 1'b0;
		end else if (en) begin
			ld_s2 <= req_s1.ld;
			ld_s3 <= ld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s2 <= req_s1.idx;
			val_s2 <= req_s1.value;
			cy_s2  <= req_s1.cy;
			idx_s3 <= idx_s2;
			val_s3 <= val_s2;
		end
	end

	pn2_ram #(.DEPTH(TABLE_SIZE), .WIDTH(ENTRY_W)) u_ram_a (
		.clk(clk), .we(en && req_s1.ld), .waddr(req_s1.idx), .wdata(req_s1.value),
		.re(en), .raddr0(req_s1.cx), .raddr1(cx1), .rdata0_q(pa_s2), .rdata1_q(pb_s2)
	);

	pn2_ram #(.DEPTH(TABLE_SIZE), .WIDTH(ENTRY_W)) u_ram_b (
		.clk(clk), .we(en && ld_s2), .waddr(idx_s2), .wdata(val_s2),
		.re(en), .raddr0(a_addr), .raddr1(a1_addr), .rdata0_q(aa_s3), .rdata1_q(ab_s3)
	);

	pn2_ram #(.DEPTH(TABLE_SIZE), .WIDTH(ENTRY_W)) u_ram_c (
		.clk(clk), .we(en && ld_s2), .waddr(idx_s2), .wdata(val_s2),
		.re(en), .raddr0(b_addr), .raddr1(b1_addr), .rdata0_q(ba_s3), .rdata1_q(bb_s3)
	);

	pn2_ram #(.DEPTH(TABLE_SIZE), .WIDTH(ENTRY_W)) u_ram_d (
		.clk(clk), .we(en && ld_s3), .waddr(idx_s3), .wdata(val_s3),
		.re(en), .raddr0(IDX_W'(aa_s3)), .raddr1(IDX_W'(ab_s3)),
		.rdata0_q(haa_s4), .rdata1_q(hab_s4)
	);

	pn2_ram #(.DEPTH(TABLE_SIZE), .WIDTH(ENTRY_W)) u_ram_e (
		.clk(clk), .we(en && ld_s3), .waddr(idx_s3), .wdata(val_s3),
		.re(en), .raddr0(IDX_W'(ba_s3)), .raddr1(IDX_W'(bb_s3)),
		.rdata0_q(hba_s4), .rdata1_q(hbb_s4)
	);

	assign hash_s4.h00 = haa_s4[HASH_W-1:0];
	assign hash_s4.h10 = hba_s4[HASH_W-1:0];
	assign hash_s4.h01 = hab_s4[HASH_W-1:0];
	assign hash_s4.h11 = hbb_s4[HASH_W-1:0];

endmodule

`default_nettype wire

/* rtl/pn2_fade.sv */
// Quintic fade of one coordinate fraction, three multiply stages.
// Depends on pn2_pkg.
`default_nettype none

module pn2_fade (
	input  logic                          clk,
	input  logic                          en,
	input  logic [pn2_pkg::FRAC_BITS-1:0] t_s1,
	output logic [pn2_pkg::U_W-1:0]       fade_s4,
	output logic [pn2_pkg::FRAC_BITS-1:0] t_s4
);
	import pn2_pkg::*;

	localparam int F = FRAC_BITS;
	localparam logic [2*F-1:0]   HALF2 = (2*F)'(1 << (F - 1));
	localparam logic [F+P_W-1:0] HALF3 = (F+P_W)'(1 << (F - 1));
	localparam logic [P_W-1:0]   TEN_ONE = P_W'(10 * (1 << F));

	logic [F-1:0]     t_s2, t2_s2, t_s3, t3_s3;
	logic [P_W-1:0]   p_s3;
	logic [2*F-1:0]   sq, sq_r, cu, cu_r;
	logic [F+P_W-1:0] fp, fp_r;
	logic [P_W-1:0]   t2e, te, p_next;

	always_comb begin
		sq   = t_s1 * t_s1;
		sq_r = sq + HALF2;
		cu   = t2_s2 * t_s2;
		cu_r = cu + HALF2;
		// 6t^2 - 15t + 10; the true value is positive and fits, so wrap is harmless
		t2e    = P_W'(t2_s2);
		te     = P_W'(t_s2);
		p_next = (t2e << 2) + (t2e << 1) - (te << 4) + te + TEN_ONE;
		fp     = t3_s3 * p_s3;
		fp_r   = fp + HALF3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s2    <= t_s1;
			t2_s2   <= sq_r[2*F-1:F];
			t_s3    <= t_s2;
			t3_s3   <= cu_r[2*F-1:F];
			p_s3    <= p_next;
			t_s4    <= t_s3;
			fade_s4 <= fp_r[F+U_W-1:F];
		end
	end

endmodule

`default_nettype wire

/* rtl/pn2_mix.sv */
// Gradient selection, two lerp levels and output scaling with the output register.
// Depends on pn2_pkg.
`default_nettype none

module pn2_mix (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                ev_s4,
	input  pn2_pkg::hash_t                      hash_s4,
	input  logic [pn2_pkg::U_W-1:0]             u_s4,
	input  logic [pn2_pkg::U_W-1:0]             v_s4,
	input  logic [pn2_pkg::FRAC_BITS-1:0]       fx_s4,
	input  logic [pn2_pkg::FRAC_BITS-1:0]       fy_s4,
	output logic                                vld_s9,
	output logic signed [pn2_pkg::OUT_W-1:0]    val_s9
);
	import pn2_pkg::*;

	localparam int F    = FRAC_BITS;
	localparam int M1_W = U_W + 1 + D_W;
	localparam int M2_W = U_W + 1 + DL_W;
	localparam int O_W  = R_W + 1;
	localparam logic signed [M1_W-1:0] HALF1 = M1_W'(1 << (F - 1));
	localparam logic signed [M2_W-1:0] HALF2 = M2_W'(1 << (F - 1));
	localparam logic signed [O_W-1:0]  ONE_R = O_W'((1 << F) + 1);
	localparam logic signed [O_W-1:0]  O_MAX = O_W'((1 << (OUT_W - 1)) - 1);
	localparam logic signed [O_W-1:0]  O_MIN = -O_W'(1 << (OUT_W - 1));

	// +-u +-2v; hash bit 2 swaps the roles of dx and dy
	function automatic logic signed [G_W-1:0] grad(
		input logic [HASH_W-1:0] h,
		input logic signed [F:0] dx,
		input logic signed [F:0] dy
	);
		logic signed [G_W-1:0] gu, gv, pu, pv;
		gu = h[2] ? G_W'(dy) : G_W'(dx);
		gv = h[2] ? G_W'(dx) : G_W'(dy);
		pu = h[0] ? -gu : gu;
		pv = h[1] ? -(gv <<< 1) : (gv <<< 1);
		return pu + pv;
	endfunction

	logic                   vld_s5, vld_s6, vld_s7, vld_s8;
	logic signed [G_W-1:0]  g00_s5, g01_s5, g00_s6, g01_s6;
	logic signed [D_W-1:0]  d0_s5, d1_s5;
	logic [U_W-1:0]         u_s5, v_s5, v_s6, v_s7;
	logic signed [L_W-1:0]  q0_s6, q1_s6, l0_s7, l0_s8, qv_s8;
	logic signed [DL_W-1:0] dl_s7;

	logic signed [F:0]      dx0, dx1, dy0, dy1;
	logic signed [G_W-1:0]  g00, g10, g01, g11;
	logic signed [M1_W-1:0] m0, m1, m0_r, m1_r;
	logic signed [L_W-1:0]  l0, l1;
	logic signed [M2_W-1:0] mv, mv_r;
	logic signed [R_W-1:0]  res;
	logic signed [O_W-1:0]  o_full;
	logic signed [OUT_W-1:0] o_sat;

	always_comb begin
		// corner offsets: f and f - one (sign bit set, same low bits)
		dx0 = {1'b0, fx_s4};
		dx1 = {1'b1, fx_s4};
		dy0 = {1'b0, fy_s4};
		dy1 = {1'b1, fy_s4};
		g00 = grad(hash_s4.h00, dx0, dy0);
		g10 = grad(hash_s4.h10, dx1, dy0);
		g01 = grad(hash_s4.h01, dx0, dy1);
		g11 = grad(hash_s4.h11, dx1, dy1);

		m0   = $signed({1'b0, u_s5}) * d0_s5;
		m1   = $signed({1'b0, u_s5}) * d1_s5;
		m0_r = (m0 + HALF1) >>> F;
		m1_r = (m1 + HALF1) >>> F;

		l0 = L_W'(g00_s6) + q0_s6;
		l1 = L_W'(g01_s6) + q1_s6;

		mv   = $signed({1'b0, v_s7}) * dl_s7;
		mv_r = (mv + HALF2) >>> F;

		res    = R_W'(l0_s8) + R_W'(qv_s8);
		o_full = (O_W'(res) + ONE_R) >>> 1;
		if (o_full > O_MAX) begin
			o_sat = OUT_W'(O_MAX);
		end else if (o_full < O_MIN) begin
			o_sat = OUT_W'(O_MIN);
		end else begin
			o_sat = OUT_W'(o_full);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s5 <= ev_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			g00_s5 <= g00;
			g01_s5 <= g01;
			d0_s5  <= D_W'(g10) - D_W'(g00);
			d1_s5  <= D_W'(g11) - D_W'(g01);
			u_s5   <= u_s4;
			v_s5   <= v_s4;

			g00_s6 <= g00_s5;
			g01_s6 <= g01_s5;
			q0_s6  <= L_W'(m0_r);
			q1_s6  <= L_W'(m1_r);
			v_s6   <= v_s5;

			l0_s7  <= l0;
			dl_s7  <= DL_W'(l1) - DL_W'(l0);
			v_s7   <= v_s6;

			l0_s8  <= l0_s7;
			qv_s8  <= L_W'(mv_r);

			val_s9 <= o_sat;
		end
	end

`ifndef NO_ASSERTIONS
	a_s8_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_s8 |=> vld_s9)
		else $error("mix: stage 8 beat did not reach the output register");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable({vld_s5, vld_s6, vld_s7, vld_s8}))
		else $error("mix: valid bits moved during a stall");

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s9 |-> (val_s9 >= -OUT_W'(2 << F)) && (val_s9 <= OUT_W'((3 << F) - 1)))
		else $error("mix: noise value outside the reachable range");
`endif

endmodule

`default_nettype wire

/* rtl/perlin_noise_2d_core.sv */
// Top level of the 2D gradient noise core: stream ports, input stage and pipeline control.
// Depends on pn2_pkg, pn2_hash, pn2_fade and pn2_mix (pn2_ram below pn2_hash).
`default_nettype none

// Streaming 2D gradient noise. Each input beat is either a table load (tuser = 0),
// which writes one byte of the 256-entry permutation table and yields no output,
// or an evaluate (tuser = 1), which yields exactly one output beat: the noise at
// (x, y) scaled to (n + 1) / 2, signed with 16 fraction bits. The core accepts one
// beat per cycle, with no gaps, for as long as the output is taken or no result is waiting.
// The whole pipeline advances as one and holds when the output is not taken, so
// throughput is set only by the output handshake. A load affects every evaluate
// accepted after it and none accepted before, even with evaluates still in flight.
// Table contents are undefined after reset: load every entry before evaluating.
module perlin_noise_2d_core (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [7:0] table_index, [15:8] table_value, [39:16] x_coord, [63:40] y_coord
	input  logic [63:0] s_axis_tdata,
	// [0] cmd: 0 load, 1 evaluate
	input  logic [0:0]  s_axis_tuser,

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [18:0] noise_value (signed), [23:19] zero
	output logic [23:0] m_axis_tdata
);
	import pn2_pkg::*;

	localparam int X_LO = TIDX_W + ENTRY_W;
	localparam int Y_LO = X_LO + COORD_W;
	localparam int OUT_PAD = 24 - OUT_W;

	// one enable for every stage: advance unless a finished result is stuck
	logic pipe_en;
	assign pipe_en       = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = pipe_en;

	// stage 1: registered input beat
	logic                valid_s1;
	cmd_t                cmd_s1;
	logic [TIDX_W-1:0]   idx_s1;
	logic [ENTRY_W-1:0]  val_s1;
	logic [COORD_W-1:0]  x_s1, y_s1;
	// evaluate flags for stages 2..4 (stages 5..9 live in the mixer)
	logic                ev_s2, ev_s3, ev_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			ev_s2    <= 1'b0;
			ev_s3    <= 1'b0;
			ev_s4    <= 1'b0;
		end else if (pipe_en) begin
			valid_s1 <= s_axis_tvalid;
			ev_s2    <= valid_s1 && (cmd_s1 == CMD_EVAL);
			ev_s3    <= ev_s2;
			ev_s4    <= ev_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			cmd_s1 <= cmd_t'(s_axis_tuser[0]);
			idx_s1 <= s_axis_tdata[TIDX_W-1:0];
			val_s1 <= s_axis_tdata[X_LO-1:TIDX_W];
			x_s1   <= s_axis_tdata[Y_LO-1:X_LO];
			y_s1   <= s_axis_tdata[Y_LO+COORD_W-1:Y_LO];
		end
	end

	// table request: integer parts of the coordinates wrap to the table size
	tbl_req_t req_s1;
	assign req_s1.ld    = valid_s1 && (cmd_s1 == CMD_LOAD);
	assign req_s1.idx   = IDX_W'(idx_s1);
	assign req_s1.value = val_s1;
	assign req_s1.cx    = IDX_W'(x_s1 >> FRAC_BITS);
	assign req_s1.cy    = IDX_W'(y_s1 >> FRAC_BITS);

	hash_t hash_s4;

	pn2_hash u_hash (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (pipe_en),
		.req_s1  (req_s1),
		.hash_s4 (hash_s4)
	);

	logic [U_W-1:0]       u_s4, v_s4;
	logic [FRAC_BITS-1:0] fx_s4, fy_s4;

	pn2_fade u_fade_x (
		.clk     (clk),
		.en      (pipe_en),
		.t_s1    (x_s1[FRAC_BITS-1:0]),
		.fade_s4 (u_s4),
		.t_s4    (fx_s4)
	);

	pn2_fade u_fade_y (
		.clk     (clk),
		.en      (pipe_en),
		.t_s1    (y_s1[FRAC_BITS-1:0]),
		.fade_s4 (v_s4),
		.t_s4    (fy_s4)
	);

	logic signed [OUT_W-1:0] noise_s9;

	pn2_mix u_mix (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (pipe_en),
		.ev_s4   (ev_s4),
		.hash_s4 (hash_s4),
		.u_s4    (u_s4),
		.v_s4    (v_s4),
		.fx_s4   (fx_s4),
		.fy_s4   (fy_s4),
		.vld_s9  (m_axis_tvalid),
		.val_s9  (noise_s9)
	);

	assign m_axis_tdata = {OUT_PAD'(0), noise_s9};

`ifndef NO_ASSERTIONS
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("core: input accepted while the output is stalled");

	a_eval_advances: assert property (@(posedge clk) disable iff (!arst_n)
		pipe_en && valid_s1 && (cmd_s1 == CMD_EVAL) |=> ev_s2)
		else $error("core: evaluate beat lost between stage 1 and stage 2");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!pipe_en |=> $stable({valid_s1, ev_s2, ev_s3, ev_s4}))
		else $error("core: front valid bits moved during a stall");
`endif

endmodule

`default_nettype wire

/* bench/perlin_noise_2d_core_tb.sv */
// Self-checking bench for perlin_noise_2d_core: fills the permutation table, runs a
// directed probe list and a random load/evaluate mix, and scores each noise beat
// against an in-bench fixed-point model. Depends on pn2_pkg and the core RTL.
`timescale 1ns / 1ps

module perlin_noise_2d_core_tb;
	import pn2_pkg::*;

	localparam longint FIX_ONE        = longint'(1) << FRAC_BITS;
	localparam longint NOISE_MAX      = (longint'(1) << (OUT_W - 1)) - 1;
	localparam longint NOISE_MIN      = -(longint'(1) << (OUT_W - 1));
	localparam int     HOLD_CYCLES    = 300;
	localparam int     WATCHDOG_LIMIT = 5000;
	localparam int     DRAIN_CYCLES   = 24;
	localparam int     LOAD_PCT       = 15;
	// both fractions zero: the fade weights are zero and the origin corner dots to zero, n = 0
	localparam logic [OUT_W-1:0] CORNER_NOISE = 19'h08000;

	typedef struct packed {
		cmd_t                 cmd;
		logic [TIDX_W-1:0]    idx;
		logic [ENTRY_W-1:0]   val;
		logic [COORD_W-1:0]   x;
		logic [COORD_W-1:0]   y;
		logic                 typed;
		logic [OUT_W-1:0]     noise;
	} probe_t;

	localparam int NUM_PROBES = 20;

	probe_t probes [NUM_PROBES] = '{
		'{CMD_LOAD, 8'h00, 8'hFF, 24'h000000, 24'h000000, 1'b0, 19'h0},
		'{CMD_LOAD, 8'hFF, 8'h00, 24'h000000, 24'h000000, 1'b0, 19'h0},
		'{CMD_EVAL, 8'h00, 8'h00, 24'h000000, 24'h000000, 1'b1, CORNER_NOISE},
		'{CMD_EVAL, 8'h00, 8'h00, 24'hFF0000, 24'hFF0000, 1'b1, CORNER_NOISE},
		'{CMD_EVAL, 8'h00, 8'h00, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 19'h0},
		'{CMD_EVAL, 8'h00, 8'h00, 24'h00FFFF, 24'h000000, 1'b0, 19'h0},
		'{CMD_EVAL, 8'h00, 8'h00, 24'h000000, 24'h00FFFF, 1'b0, 19'h0},
		'{CMD_EVAL, 8'h00, 8'h00, 24'h008000, 24'h008000, 1'b0, 19'h0},
		'{CMD_EVAL, 8'h00, 8'h00, 24'hFF8000, 24'h00FFFF, 1'b0, 19'h0},
		'{CMD_LOAD, 8'h55, 8'hAA, 24'h000000, 24'h000000, 1'b0, 19'h0},
		// evaluate right behind the load that feeds it
		'{CMD_EVAL, 8'h00, 8'h00, 24'h550001, 24'hAA0001, 1'b0, 19'h0},
		'{CMD_LOAD, 8'hAA, 8'h55, 24'h000000, 24'h000000, 1'b0, 19'h0},
		'{CMD_EVAL, 8'h00, 8'h00, 24'hAA4000, 24'h55C000, 1'b0, 19'h0},
		'{CMD_EVAL, 8'h00, 8'h00, 24'h7F0000, 24'h80FFFF, 1'b0, 19'h0},
		'{CMD_EVAL, 8'h00, 8'h00, 24'h123456, 24'h654321, 1'b0, 19'h0},
		'{CMD_LOAD, 8'h80, 8'h7F, 24'h000000, 24'h000000, 1'b0, 19'h0},
		'{CMD_LOAD, 8'h7F, 8'h80, 24'h000000, 24'h000000, 1'b0, 19'h0},
		'{CMD_EVAL, 8'h00, 8'h00, 24'h7FFFFF, 24'h7FFFFF, 1'b0, 19'h0},
		'{CMD_EVAL, 8'h00, 8'h00, 24'h800000, 24'h7F0000, 1'b1, CORNER_NOISE},
		'{CMD_EVAL, 8'h00, 8'h00, 24'h000001, 24'hFFFF00, 1'b0, 19'h0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic [0:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;

	logic [ENTRY_W-1:0] perm_shadow [TABLE_SIZE];
	logic [OUT_W-1:0]   noise_due [$];
	logic [OUT_W-1:0]   due_noise;
	logic               beat_typed = 1'b0;
	logic [OUT_W-1:0]   beat_noise = '0;
	int                 fail_count = 0;
	int                 tx_idle_pct = 0;
	int                 rx_idle_pct = 0;
	int                 stall_cycles = 0;
	int                 hold_left = 0;
	bit                 hold_req = 1'b0;

	perlin_noise_2d_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// round to nearest, ties toward +inf
	function automatic longint round_shift(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint quintic_fade(longint t);
		longint t2, t3, p;
		t2 = round_shift(t * t, FRAC_BITS);
		t3 = round_shift(t2 * t, FRAC_BITS);
		p = 6 * t2 - 15 * t + 10 * FIX_ONE;
		return round_shift(t3 * p, FRAC_BITS);
	endfunction

	function automatic longint blend(longint a, longint b, longint w);
		return a + round_shift(w * (b - a), FRAC_BITS);
	endfunction

	// +-u +-2v, u/v swapped when hash bit 2 is set
	function automatic longint corner_grad(logic [ENTRY_W-1:0] hash, longint dx, longint dy);
		longint u, v;
		u = hash[2] ? dy : dx;
		v = hash[2] ? dx : dy;
		if (hash[0])
			u = -u;
		if (hash[1])
			v = -v;
		return u + 2 * v;
	endfunction

	function automatic logic [OUT_W-1:0] predict_noise(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
		logic [IDX_W-1:0] cx, cy, cx1, a, a1, b, b1;
		logic [ENTRY_W-1:0] aa, ab, ba, bb;
		longint fx, fy, wu, wv, g00, g10, g01, g11, l0, l1, res, o;
		cx  = x[COORD_W-1:FRAC_BITS];
		cy  = y[COORD_W-1:FRAC_BITS];
		fx  = longint'(x[FRAC_BITS-1:0]);
		fy  = longint'(y[FRAC_BITS-1:0]);
		wu  = quintic_fade(fx);
		wv  = quintic_fade(fy);
		cx1 = cx + 1'b1;
		a   = perm_shadow[cx] + cy;
		a1  = a + 1'b1;
		b   = perm_shadow[cx1] + cy;
		b1  = b + 1'b1;
		aa  = perm_shadow[a];
		ab  = perm_shadow[a1];
		ba  = perm_shadow[b];
		bb  = perm_shadow[b1];
		g00 = corner_grad(perm_shadow[aa], fx, fy);
		g10 = corner_grad(perm_shadow[ba], fx - FIX_ONE, fy);
		g01 = corner_grad(perm_shadow[ab], fx, fy - FIX_ONE);
		g11 = corner_grad(perm_shadow[bb], fx - FIX_ONE, fy - FIX_ONE);
		l0  = blend(g00, g10, wu);
		l1  = blend(g01, g11, wu);
		res = blend(l0, l1, wv);
		o   = round_shift(res + FIX_ONE, 1);
		if (o > NOISE_MAX)
			o = NOISE_MAX;
		if (o < NOISE_MIN)
			o = NOISE_MIN;
		return o[OUT_W-1:0];
	endfunction

	// Fractions lean on the edges of the cell now and then.
	function automatic logic [COORD_W-1:0] pick_coord();
		logic [FRAC_BITS-1:0] f;
		case ($urandom_range(7))
			0: f = '0;
			1: f = '1;
			2: f = 16'h8000;
			default: f = 16'($urandom);
		endcase
		return {8'($urandom), f};
	endfunction

	// Called at any point; returns in the step of the accepting edge with tvalid still high.
	task automatic send_beat(input cmd_t cmd, input logic [TIDX_W-1:0] idx,
			input logic [ENTRY_W-1:0] val, input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y, input logic typed, input logic [OUT_W-1:0] noise);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {y, x, val, idx};
		beat_typed = typed;
		beat_noise = noise;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic random_burst(input int count);
		int n;
		for (n = 0; n < count; n++) begin
			if ($urandom_range(99) < LOAD_PCT)
				send_beat(CMD_LOAD, 8'($urandom), 8'($urandom), pick_coord(), pick_coord(),
					1'b0, '0);
			else
				send_beat(CMD_EVAL, 8'($urandom), 8'($urandom), pick_coord(), pick_coord(),
					1'b0, '0);
		end
	endtask

	// sink: random tready, or a long hold-off when asked
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Table shadow and expectations follow input acceptance; output beats are scored here.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser == CMD_LOAD)
					perm_shadow[s_axis_tdata[7:0]] = s_axis_tdata[15:8];
				else if (beat_typed)
					noise_due = {noise_due, beat_noise};
				else
					noise_due = {noise_due,
						predict_noise(s_axis_tdata[39:16], s_axis_tdata[63:40])};
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (noise_due.size() == 0) begin
					$display("%0t: noise beat %h with nothing expected", $time, m_axis_tdata);
					fail_count++;
				end else begin
					due_noise = noise_due.pop_front();
					if (m_axis_tdata !== {{(24 - OUT_W){1'b0}}, due_noise}) begin
						$display("%0t: noise_value expected %0d (%h) got %0d (%h)", $time,
							$signed(due_noise), {{(24 - OUT_W){1'b0}}, due_noise},
							$signed(m_axis_tdata[OUT_W-1:0]), m_axis_tdata);
						fail_count++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: timeout, no beat moved for %0d cycles, %0d results outstanding",
				$time, WATCHDOG_LIMIT, noise_due.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		logic [ENTRY_W-1:0] shuffled [TABLE_SIZE];
		logic [ENTRY_W-1:0] swap;
		int i, j;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		tx_idle_pct = 24;
		rx_idle_pct = 67;

		// Table is undefined after reset: write every entry with a shuffled permutation.
		for (i = 0; i < TABLE_SIZE; i++)
			shuffled[i] = ENTRY_W'(i);
		for (i = TABLE_SIZE - 1; i > 0; i--) begin
			j = $urandom_range(i);
			swap = shuffled[i];
			shuffled[i] = shuffled[j];
			shuffled[j] = swap;
		end
		for (i = 0; i < TABLE_SIZE; i++)
			send_beat(CMD_LOAD, TIDX_W'(i), shuffled[i], pick_coord(), pick_coord(), 1'b0, '0);

		for (i = 0; i < NUM_PROBES; i++)
			send_beat(probes[i].cmd, probes[i].idx, probes[i].val, probes[i].x, probes[i].y,
				probes[i].typed, probes[i].noise);

		random_burst(540);

		tx_idle_pct = 67;
		rx_idle_pct = 24;
		random_burst(540);

		// free-running both ends, with one long sink stall to back the pipe up
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		random_burst(40);
		hold_req = 1'b1;
		random_burst(480);

		@(negedge clk);
		s_axis_tvalid <= 1'b0;

		while (noise_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

/* perlin_noise_2d_core.f */
rtl/pn2_pkg.sv
rtl/pn2_ram.sv
rtl/pn2_hash.sv
rtl/pn2_fade.sv
rtl/pn2_mix.sv
rtl/perlin_noise_2d_core.sv
bench/perlin_noise_2d_core_tb.sv
